@@ hw/rtl/ampq_pkg.sv @@
// Package for the array max-priority queue: sizes, codes, entry type and
// the command/status structs between controller and datapath. No dependencies.
package ampq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_PEEK   = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [15:0] prio;
    logic [31:0] value;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic ins;
    logic rd_start;
    logic rd_from_best;
    logic rd_run;
    logic cmp;
    logic wb;
    logic found;
    logic dec;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic ins_ok;
    logic need_scan;
    logic is_del;
    logic last_data;
    logic best_last;
    logic out_free;
  } dp_sts_t;

endpackage

@@ hw/rtl/ampq_dpath.sv @@
// Datapath: entry memory, fill count, scan/shift read pipeline, best-entry
// tracking and the output register. Depends on ampq_pkg.
module ampq_dpath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [47:0]      s_axis_tdata_i,   // value[31:0], prio[47:32]
  input  logic [1:0]       s_axis_tuser_i,   // op[1:0]
  input  ampq_pkg::dp_cmd_t cmd_i,
  output ampq_pkg::dp_sts_t sts_o,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,   // value_out[31:0], prio_out[47:32]
  output logic [1:0]       m_axis_tuser_o    // status[1:0]
);
  import ampq_pkg::*;

  entry_t          mem [DEPTH];
  logic [1:0]      op_q;
  entry_t          in_q;
  logic [CW-1:0]   count_q;
  logic [CW-1:0]   cnt_m1;
  logic [IW-1:0]   ptr_q;
  logic            act_q;
  logic [IW-1:0]   tag_q;
  logic            tag_vld_q;
  entry_t          rdata_q;
  entry_t          best_q;
  logic [IW-1:0]   best_idx_q;
  logic [31:0]     res_value_q;
  logic [15:0]     res_prio_q;
  logic [1:0]      res_st_q;
  logic            m_valid_q;
  logic [47:0]     m_data_q;
  logic [1:0]      m_user_q;
  logic            full;
  logic            empty;
  logic            issue;
  logic            we;
  logic [IW-1:0]   waddr;
  entry_t          wdata;

  assign cnt_m1 = CW'(count_q - 1'b1);
  assign full   = (count_q == CW'(DEPTH));
  assign empty  = (count_q == '0);
  assign issue  = cmd_i.rd_run && act_q;

  assign sts_o.ins_ok    = (op_q == OP_INSERT) && !full;
  assign sts_o.need_scan = ((op_q == OP_PEEK) || (op_q == OP_DELETE)) && !empty;
  assign sts_o.is_del    = (op_q == OP_DELETE);
  assign sts_o.last_data = tag_vld_q && (CW'(tag_q) == cnt_m1);
  assign sts_o.best_last = (CW'(best_idx_q) == cnt_m1);
  assign sts_o.out_free  = !m_valid_q || m_axis_tready_i;

  always_comb begin
    we    = 1'b0;
    waddr = count_q[IW-1:0];
    wdata = in_q;
    if (cmd_i.ins) begin
      we = 1'b1;
    end else if (cmd_i.wb && tag_vld_q) begin
      we    = 1'b1;
      waddr = IW'(tag_q - 1'b1);
      wdata = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (issue) begin
      rdata_q <= mem[ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      act_q     <= 1'b0;
      tag_vld_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_i.ins) begin
        count_q <= CW'(count_q + 1'b1);
      end else if (cmd_i.dec) begin
        count_q <= CW'(count_q - 1'b1);
      end
      if (cmd_i.rd_start) begin
        act_q     <= 1'b1;
        tag_vld_q <= 1'b0;
      end else begin
        tag_vld_q <= issue;
        if (issue && (CW'(ptr_q) == cnt_m1)) begin
          act_q <= 1'b0;
        end
      end
      if (cmd_i.emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= s_axis_tuser_i;
      in_q  <= s_axis_tdata_i;
    end
    if (cmd_i.rd_start) begin
      ptr_q <= cmd_i.rd_from_best ? IW'(best_idx_q + 1'b1) : '0;
    end else if (issue) begin
      ptr_q <= IW'(ptr_q + 1'b1);
    end
    if (issue) begin
      tag_q <= ptr_q;
    end
    if (cmd_i.cmp && tag_vld_q) begin
      if ((tag_q == '0) || (rdata_q.prio > best_q.prio)) begin
        best_q     <= rdata_q;
        best_idx_q <= tag_q;
      end
    end
    if (cmd_i.decode) begin
      res_value_q <= '0;
      res_prio_q  <= '0;
      if ((op_q == OP_INSERT) && full) begin
        res_st_q <= ST_FULL;
      end else if (((op_q == OP_PEEK) || (op_q == OP_DELETE)) && empty) begin
        res_st_q <= ST_EMPTY;
      end else begin
        res_st_q <= ST_OK;
      end
    end else if (cmd_i.found) begin
      res_value_q <= best_q.value;
      res_prio_q  <= best_q.prio;
    end
    if (cmd_i.emit) begin
      m_data_q <= {res_prio_q, res_value_q};
      m_user_q <= res_st_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

@@ hw/rtl/ampq_ctrl.sv @@
// Controller FSM: sequences decode, scan, gap-closing shift and result load.
// Depends on ampq_pkg.
module ampq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  ampq_pkg::dp_sts_t sts_i,
  output ampq_pkg::dp_cmd_t cmd_o
);
  import ampq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_FOUND  = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;

  assign s_axis_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        cmd_o.ins    = sts_i.ins_ok;
        if (sts_i.need_scan) begin
          cmd_o.rd_start = 1'b1;
          state_d        = S_SCAN;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_SCAN: begin
        cmd_o.rd_run = 1'b1;
        cmd_o.cmp    = 1'b1;
        if (sts_i.last_data) begin
          state_d = S_FOUND;
        end
      end
      S_FOUND: begin
        cmd_o.found = 1'b1;
        if (!sts_i.is_del) begin
          state_d = S_RESULT;
        end else if (sts_i.best_last) begin
          cmd_o.dec = 1'b1;
          state_d   = S_RESULT;
        end else begin
          cmd_o.rd_start     = 1'b1;
          cmd_o.rd_from_best = 1'b1;
          state_d            = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd_o.rd_run = 1'b1;
        cmd_o.wb     = 1'b1;
        if (sts_i.last_data) begin
          cmd_o.dec = 1'b1;
          state_d   = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/array_max_priority_queue.sv @@
// Top level of the array max-priority queue: controller plus datapath.
// Insert, an unused op or an empty/full case goes from decode straight to the
// result; peek scans the N stored entries, one memory read per cycle; delete
// also moves each entry above the removed one down a place, none if it is last.
// One transaction at a time; the next is taken while a result waits.
// Reset (async, active low) empties the queue and clears the handshake.
module array_max_priority_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // value_in[31:0], prio_in[47:32]
  input  logic [1:0]  s_axis_tuser_i,   // op[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // value_out[31:0], prio_out[47:32]
  output logic [1:0]  m_axis_tuser_o    // status[1:0]
);
  import ampq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ampq_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  ampq_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

@@ hw/rtl/ampq_checker.sv @@
// Port-level assertions for array_max_priority_queue and their bind.
// Depends on ampq_pkg.
module ampq_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,
  input  logic [1:0]  s_axis_tuser_i,
  input  logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic [47:0] m_axis_tdata_o,
  input  logic [1:0]  m_axis_tuser_o
);
  import ampq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second transaction taken while busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == ST_OK) || (m_axis_tuser_o == ST_FULL) ||
      (m_axis_tuser_o == ST_EMPTY))
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != ST_OK) |-> (m_axis_tdata_o == '0))
    else $error("non-zero data with error status");

endmodule

bind array_max_priority_queue ampq_checker u_ampq_checker (.*);
